>>> hdl/utv_pkg.sv
// Shared types for the UTF-8 text validator: byte classes and the queued item.
package utv_pkg;

  // Class of one received byte, decided in the front part.
  typedef enum logic [2:0] {
    KIND_NUL       = 3'd0,
    KIND_ASCII_OK  = 3'd1,
    KIND_ASCII_BAD = 3'd2,
    KIND_LEAD2     = 3'd3,
    KIND_LEAD3     = 3'd4,
    KIND_LEAD4     = 3'd5,
    KIND_INVALID   = 3'd6
  } byte_kind_t;

  // One classified byte as it travels from the front part to the back part.
  typedef struct packed {
    byte_kind_t  kind;
    logic        is_cont;
    logic [5:0]  low_bits;
  } utv_item_t;

  // The queue between the two parts.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = 1;
  localparam int unsigned QUEUE_CW    = 2;

endpackage

>>> hdl/utv_front.sv
// Front part: accepts text bytes and classifies each one for the decoder.
module utv_front import utv_pkg::*; (
  input  logic [7:0]  text_byte,
  input  logic        in_valid,
  input  logic        queue_full,
  output logic        in_stall,
  output logic        push,
  output utv_item_t   push_item
);

  localparam logic [7:0] ASCII_LOW  = 8'h20;
  localparam logic [7:0] ASCII_DEL  = 8'h7F;
  localparam logic [7:0] LEAD2_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI   = 8'hDF;
  localparam logic [7:0] LEAD3_LO   = 8'hE0;
  localparam logic [7:0] LEAD3_HI   = 8'hEF;
  localparam logic [7:0] LEAD4_LO   = 8'hF0;
  localparam logic [7:0] LEAD4_HI   = 8'hF4;
  localparam logic [1:0] CONT_TAG   = 2'b10;

  byte_kind_t kind;

  always_comb begin
    if (text_byte == 8'h00) begin
      kind = KIND_NUL;
    end else if (text_byte[7] == 1'b0) begin
      if (text_byte < ASCII_LOW || text_byte == ASCII_DEL) begin
        kind = KIND_ASCII_BAD;
      end else begin
        kind = KIND_ASCII_OK;
      end
    end else if (text_byte >= LEAD2_LO && text_byte <= LEAD2_HI) begin
      kind = KIND_LEAD2;
    end else if (text_byte >= LEAD3_LO && text_byte <= LEAD3_HI) begin
      kind = KIND_LEAD3;
    end else if (text_byte >= LEAD4_LO && text_byte <= LEAD4_HI) begin
      kind = KIND_LEAD4;
    end else begin
      kind = KIND_INVALID;
    end
  end

  assign in_stall            = queue_full;
  assign push                = in_valid && !queue_full;
  assign push_item.kind      = kind;
  assign push_item.is_cont   = (text_byte[7:6] == CONT_TAG);
  assign push_item.low_bits  = text_byte[5:0];

endmodule

>>> hdl/utv_queue.sv
// Short queue of classified bytes between the front and back parts.
module utv_queue import utv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  utv_item_t  push_item,
  output logic       full,
  output logic       head_valid,
  output utv_item_t  head_item,
  input  logic       pop_ready
);

  utv_item_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr;
  logic [QUEUE_AW-1:0]     rd_ptr;
  logic [QUEUE_CW-1:0]     count;
  logic                    pop;

  assign full       = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];
  assign pop        = head_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QUEUE_CW'(1);
        2'b01:   count <= count - QUEUE_CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/utv_back.sv
// Back part: decode state, capacity register and the registered verdict.
module utv_back import utv_pkg::*; #(
  parameter int unsigned MAX_CAPACITY = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [8:0] text_capacity,
  input  logic       head_valid,
  input  utv_item_t  head_item,
  output logic       pop_ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       text_ok,
  output logic [8:0] text_length
);

  localparam int unsigned CW_RAW = $clog2(MAX_CAPACITY + 1);
  localparam int unsigned EW     = (CW_RAW > 9) ? CW_RAW : 9;
  localparam int unsigned CNT_W  = $clog2(MAX_CAPACITY);
  localparam int unsigned CAP_RESET = (MAX_CAPACITY < 256) ? MAX_CAPACITY : 256;

  localparam logic [20:0] MIN_CLASS1 = 21'h000080;
  localparam logic [20:0] MIN_CLASS2 = 21'h000800;
  localparam logic [20:0] MIN_CLASS3 = 21'h010000;
  localparam logic [20:0] MAX_POINT  = 21'h10FFFF;
  localparam logic [20:0] SURR_LO    = 21'h00D800;
  localparam logic [20:0] SURR_HI    = 21'h00DFFF;
  localparam logic [20:0] CTRL_LIMIT = 21'h000020;
  localparam logic [20:0] C1_LO      = 21'h00007F;
  localparam logic [20:0] C1_HI      = 21'h00009F;
  localparam logic [5:0]  MASK2      = 6'h1F;
  localparam logic [5:0]  MASK3      = 6'h0F;
  localparam logic [5:0]  MASK4      = 6'h07;

  function automatic logic [20:0] class_min(input logic [1:0] k);
    logic [20:0] m;
    case (k)
      2'd1:    m = MIN_CLASS1;
      2'd2:    m = MIN_CLASS2;
      2'd3:    m = MIN_CLASS3;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic point_bad(input logic [20:0] p, input logic [20:0] lo);
    return (p < lo) || (p > MAX_POINT) || (p >= SURR_LO && p <= SURR_HI) ||
           (p < CTRL_LIMIT) || (p >= C1_LO && p <= C1_HI);
  endfunction

  // Capacity is clamped once, when it is written.
  logic [EW-1:0]    cap_eff;
  logic [EW-1:0]    cap_raw;
  logic [EW-1:0]    cap_clamped;

  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [1:0]       bytes_left, bytes_left_next;
  logic [20:0]      code_point, code_point_next;
  logic [1:0]       min_class, min_class_next;
  logic             seen_error, seen_error_next;

  logic             result_fire;
  logic             ok_next;
  logic [EW-1:0]    length_next;
  logic [EW-1:0]    count_ext;
  logic [EW-1:0]    count_inc;
  logic [20:0]      shifted;
  logic             advance;

  assign cap_raw = EW'(text_capacity);

  always_comb begin
    if (cap_raw == '0) begin
      cap_clamped = EW'(1);
    end else if (cap_raw > EW'(MAX_CAPACITY)) begin
      cap_clamped = EW'(MAX_CAPACITY);
    end else begin
      cap_clamped = cap_raw;
    end
  end

  // The verdict register frees up when it is empty or its transaction completes.
  assign pop_ready = !out_valid || !out_stall;
  assign advance   = head_valid && pop_ready;

  assign count_ext = EW'(byte_count);
  assign count_inc = count_ext + EW'(1);
  assign shifted   = {code_point[14:0], head_item.low_bits};

  always_comb begin
    byte_count_next = byte_count;
    bytes_left_next = bytes_left;
    code_point_next = code_point;
    min_class_next  = min_class;
    seen_error_next = seen_error;
    result_fire     = 1'b0;
    ok_next         = 1'b0;
    length_next     = cap_eff;

    if (head_item.kind == KIND_NUL) begin
      result_fire = 1'b1;
      if (count_ext >= cap_eff) begin
        ok_next     = 1'b0;
        length_next = cap_eff;
      end else begin
        ok_next     = !seen_error && (bytes_left == 2'd0);
        length_next = count_ext;
      end
      byte_count_next = '0;
      bytes_left_next = '0;
      code_point_next = '0;
      min_class_next  = '0;
      seen_error_next = 1'b0;
    end else begin
      if (!seen_error) begin
        if (bytes_left == 2'd0) begin
          case (head_item.kind)
            KIND_ASCII_OK: begin
            end
            KIND_LEAD2: begin
              code_point_next = 21'(head_item.low_bits & MASK2);
              bytes_left_next = 2'd1;
              min_class_next  = 2'd1;
            end
            KIND_LEAD3: begin
              code_point_next = 21'(head_item.low_bits & MASK3);
              bytes_left_next = 2'd2;
              min_class_next  = 2'd2;
            end
            KIND_LEAD4: begin
              code_point_next = 21'(head_item.low_bits & MASK4);
              bytes_left_next = 2'd3;
              min_class_next  = 2'd3;
            end
            default: begin
              seen_error_next = 1'b1;
            end
          endcase
        end else if (!head_item.is_cont) begin
          seen_error_next = 1'b1;
          bytes_left_next = 2'd0;
        end else begin
          code_point_next = shifted;
          bytes_left_next = bytes_left - 2'd1;
          if (bytes_left == 2'd1) begin
            if (point_bad(shifted, class_min(min_class))) begin
              seen_error_next = 1'b1;
            end
            min_class_next = 2'd0;
          end
        end
      end

      if (count_inc >= cap_eff) begin
        // The buffer filled without a terminator.
        result_fire     = 1'b1;
        ok_next         = 1'b0;
        length_next     = cap_eff;
        byte_count_next = '0;
        bytes_left_next = '0;
        code_point_next = '0;
        min_class_next  = '0;
        seen_error_next = 1'b0;
      end else begin
        byte_count_next = count_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_eff    <= EW'(CAP_RESET);
      byte_count <= '0;
      bytes_left <= '0;
      code_point <= '0;
      min_class  <= '0;
      seen_error <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        cap_eff <= cap_clamped;
      end
      if (advance) begin
        byte_count <= byte_count_next;
        bytes_left <= bytes_left_next;
        code_point <= code_point_next;
        min_class  <= min_class_next;
        seen_error <= seen_error_next;
      end
      if (pop_ready) begin
        out_valid <= advance && result_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result_fire) begin
      text_ok     <= ok_next;
      text_length <= length_next[8:0];
    end
  end

endmodule

>>> hdl/utf8_text_validator_unit.sv
// Top level of the streaming UTF-8 text validator.
//
// Bytes of a NUL-terminated string enter on text_byte, one per transaction
// (in_valid high and in_stall low at a clock edge). A front stage classifies
// each byte and pushes it into a two-entry queue; the back stage pops one
// byte per cycle while no verdict is held by out_stall, updates the decode
// state and the byte count, and loads a verdict (text_ok, text_length) into
// an output register when the string ends at its NUL or the capacity fills.
// The verdict leaves on out_valid/out_stall; the ending byte is registered in
// the queue and then the verdict in the output register. Throughput is one
// byte per cycle, set by the back-stage decode step, unless a verdict stalls.
// The capacity is written on cfg_valid/cfg_ready (ready is always high) and
// should only change while no string is in flight. Values of zero count as
// one and values above MAX_CAPACITY count as MAX_CAPACITY.
// Reset sets the capacity to 256 (or MAX_CAPACITY if smaller), clears the
// decode state and empties the queue and the output register.
// While a verdict waits with out_stall high it holds, the back stage pauses,
// and in_stall rises once the queue holds two bytes.
module utf8_text_validator_unit import utv_pkg::*; #(
  parameter int unsigned MAX_CAPACITY = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] text_capacity,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       text_ok,
  output logic [8:0] text_length
);

  logic       push;
  utv_item_t  push_item;
  logic       queue_full;
  logic       head_valid;
  utv_item_t  head_item;
  logic       pop_ready;

  assign cfg_ready = 1'b1;

  utv_front u_front (
    .text_byte  (text_byte),
    .in_valid   (in_valid),
    .queue_full (queue_full),
    .in_stall   (in_stall),
    .push       (push),
    .push_item  (push_item)
  );

  utv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop_ready  (pop_ready)
  );

  utv_back #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_valid && cfg_ready),
    .text_capacity (text_capacity),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop_ready     (pop_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .text_ok       (text_ok),
    .text_length   (text_length)
  );

endmodule
